// ----- rtl/frd_pkg.sv -----
// Shared constants and types for the fraction reducer.
package frd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int K_W         = $clog2(VALUE_WIDTH);
    localparam int TDATA_W     = ((2 * VALUE_WIDTH + 7) / 8) * 8;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [VALUE_WIDTH:0]   t_wide;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] reduced_numerator;
        logic signed [VALUE_WIDTH-1:0] reduced_denominator;
        logic                          zero_denominator_error;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVN = 5'b00100,
        S_DIVD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ----- rtl/frd_alu.sv -----
// Shared subtractor used by both the GCD steps and the divider steps.
module frd_alu
    import frd_pkg::*;
(
    input  t_wide i_x,
    input  t_wide i_y,
    output t_wide o_diff,
    output logic  o_borrow
);

    logic [VALUE_WIDTH+1:0] w_full;

    assign w_full   = {1'b0, i_x} - {1'b0, i_y};
    assign o_diff   = w_full[VALUE_WIDTH:0];
    assign o_borrow = w_full[VALUE_WIDTH+1];

endmodule

// ----- rtl/frd_core.sv -----
// Sequencer: binary GCD, then two restoring divisions, all on one subtractor.
module frd_core
    import frd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_num,
    input  logic signed [VALUE_WIDTH-1:0] i_den,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_result                       o_res
);

    t_state           r_state, n_state;
    t_value           r_a, n_a;
    t_value           r_b, n_b;
    logic [K_W-1:0]   r_k, n_k;
    t_value           r_g, n_g;
    t_value           r_q, n_q;
    t_value           r_qn, n_qn;
    t_value           r_rem, n_rem;
    t_value           r_md, n_md;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg_n, n_neg_n;
    logic             r_neg_d, n_neg_d;
    logic             r_err, n_err;

    t_wide  w_x, w_y, w_diff;
    logic   w_borrow;
    logic   w_a_ge_b;
    t_value w_mag_n, w_mag_d;
    t_wide  w_shift;
    t_value w_q_next;
    t_value w_rem_next;
    logic   w_last_bit;

    frd_alu u_alu (
        .i_x      (w_x),
        .i_y      (w_y),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign w_mag_n  = i_num[VALUE_WIDTH-1] ? (~i_num + 1'b1) : i_num;
    assign w_mag_d  = i_den[VALUE_WIDTH-1] ? (~i_den + 1'b1) : i_den;
    assign w_a_ge_b = (r_a >= r_b);
    assign w_shift  = {r_rem, r_q[VALUE_WIDTH-1]};
    assign w_last_bit = (r_cnt == CNT_W'(VALUE_WIDTH - 1));

    // operand steering for the shared subtractor
    always_comb begin
        priority case (1'b1)
            r_state[2], r_state[3]: begin
                w_x = w_shift;
                w_y = {1'b0, r_g};
            end
            default: begin
                w_x = w_a_ge_b ? {1'b0, r_a} : {1'b0, r_b};
                w_y = w_a_ge_b ? {1'b0, r_b} : {1'b0, r_a};
            end
        endcase
    end

    // one restoring division step
    assign w_q_next   = {r_q[VALUE_WIDTH-2:0], ~w_borrow};
    assign w_rem_next = w_borrow ? w_shift[VALUE_WIDTH-1:0] : w_diff[VALUE_WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_g     = r_g;
        n_q     = r_q;
        n_qn    = r_qn;
        n_rem   = r_rem;
        n_md    = r_md;
        n_cnt   = r_cnt;
        n_neg_n = r_neg_n;
        n_neg_d = r_neg_d;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a     = w_mag_n;
                    n_b     = w_mag_d;
                    n_q     = w_mag_n;
                    n_md    = w_mag_d;
                    n_k     = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg_n = i_num[VALUE_WIDTH-1];
                    n_neg_d = i_den[VALUE_WIDTH-1];
                    n_err   = 1'b0;
                    if (i_den == '0) begin
                        n_err   = 1'b1;
                        n_q     = '0;
                        n_qn    = '0;
                        n_neg_n = 1'b0;
                        n_neg_d = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_a == '0 || r_b == '0) begin
                    n_g     = (r_a == '0 ? r_b : r_a) << r_k;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (w_a_ge_b) begin
                    n_a = w_diff[VALUE_WIDTH:1];
                end else begin
                    n_b = w_diff[VALUE_WIDTH:1];
                end
            end
            S_DIVN: begin
                n_q   = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt + 1'b1;
                if (w_last_bit) begin
                    n_qn    = w_q_next;
                    n_q     = r_md;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                n_q   = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt + 1'b1;
                if (w_last_bit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_g     <= n_g;
        r_q     <= n_q;
        r_qn    <= n_qn;
        r_rem   <= n_rem;
        r_md    <= n_md;
        r_cnt   <= n_cnt;
        r_neg_n <= n_neg_n;
        r_neg_d <= n_neg_d;
        r_err   <= n_err;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);

    assign o_res.reduced_numerator      = r_neg_n ? (~r_qn + 1'b1) : r_qn;
    assign o_res.reduced_denominator    = r_neg_d ? (~r_q + 1'b1) : r_q;
    assign o_res.zero_denominator_error = r_err;

    // b starts nonzero and a tie always clears a, never b
    a_gcd_b_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_b != '0))
        else $error("gcd operand b reached zero");

    a_div_g_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN || r_state == S_DIVD) |-> (r_g != '0))
        else $error("divisor is zero during division");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN || r_state == S_DIVD) |-> (r_rem < r_g))
        else $error("partial remainder not below divisor");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_den == '0) |=> (r_state == S_DONE && r_err))
        else $error("zero denominator not flagged");

endmodule

// ----- rtl/fraction_reducer_unit.sv -----
// Top level of the fraction reducer: stream ports, core, output register.
//
// Reduces one fraction numerator/denominator to lowest terms. The magnitudes
// go through a binary GCD (halving and subtracting, one step per cycle, at
// most 2*VALUE_WIDTH+1 steps), then the numerator and denominator magnitudes
// are each divided by the GCD with a restoring divider, one quotient bit per
// cycle. All of it runs on one shared subtractor. A zero denominator skips
// the GCD and the divisions and goes straight to done with the error flag
// set and both results zero. Signs are reapplied to each quotient separately,
// so a zero numerator yields 0 over +1 or -1. The slave side is ready only
// while the core is idle; the output register lets the core take the next
// fraction while a finished result still waits on the master side.
module fraction_reducer_unit
    import frd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // numerator, denominator
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,  // reduced_numerator, reduced_denominator
    output logic               o_m_axis_tuser   // zero_denominator_error
);

    logic    w_core_valid;
    logic    w_core_ready;
    t_result w_core_res;
    logic    r_out_valid;
    t_result r_out;

    // output slot is free when empty or being drained this cycle
    assign w_core_ready = !r_out_valid || i_m_axis_tready;

    frd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_num   (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_den   (i_s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .o_valid (w_core_valid),
        .i_ready (w_core_ready),
        .o_res   (w_core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_core_ready) begin
            r_out_valid <= w_core_valid;
        end
        if (w_core_ready && w_core_valid) begin
            r_out <= w_core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_out.reduced_denominator, r_out.reduced_numerator});
    assign o_m_axis_tuser  = r_out.zero_denominator_error;

endmodule
